// ----- hdl/lpc_pkg.sv -----
// Shared types, codes and defaults for the layered pixel compositor.
package lpc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_LAYERS     = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAYERS   = 2'd2;

  localparam logic [6:0] RST_FRAME_WIDTH  = 7'd64;
  localparam logic [6:0] RST_FRAME_HEIGHT = 7'd64;
  localparam logic [4:0] RST_NUM_LAYERS   = 5'd16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_SEND   = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [6:0] frame_width;
    logic [6:0] frame_height;
    logic [4:0] num_layers;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

endpackage

// ----- hdl/lpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lpc_seq.sv -----
// Sequencer, layer stores and shared address/layer step unit of the compositor.
module lpc_seq #(
  parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT,
  parameter int LAYERS     = lpc_pkg::DEF_LAYERS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lpc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [5:0]    in_x_i,
  input  logic [5:0]    in_y_i,
  input  logic [3:0]    target_layer_i,
  input  logic [7:0]    in_red_i,
  input  logic [7:0]    in_green_i,
  input  logic [7:0]    in_blue_i,
  output lpc_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import lpc_pkg::*;

  localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int TOTAL = LAYERS * NPIX;
  localparam int PW    = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int WCW   = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;
  localparam int HCW   = ($clog2(MAX_HEIGHT + 1) > 7) ? $clog2(MAX_HEIGHT + 1) : 7;
  localparam int NCW   = ($clog2(LAYERS + 1) > 5) ? $clog2(LAYERS + 1) : 5;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_WRITE = 4'd4;
  localparam logic [3:0] ST_TOP   = 4'd5;
  localparam logic [3:0] ST_WALK  = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_SEND  = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [5:0]    x_q, y_q;
  logic [23:0]   col_q;
  logic [LW-1:0] active_q, active_d;
  logic          vis_q, vis_d;
  logic [PW-1:0] p_q, p_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [LW-1:0] layer_q, layer_d;
  logic [23:0]   shown_q, shown_d;
  logic          accept;

  logic          pix_we, pix_re;
  logic [AW-1:0] pix_waddr, pix_raddr;
  logic [23:0]   pix_wdata, pix_rdata;
  logic          top_we, top_re;
  logic [PW-1:0] top_waddr, top_raddr;
  logic [LW-1:0] top_wdata, top_rdata;

  logic [WCW-1:0] w_lim;
  logic [HCW-1:0] h_lim;
  logic           in_bounds;
  logic [NCW-1:0] n_lim, n_max, tgt;
  logic [AW-1:0]  addr_step;
  logic [LW-1:0]  layer_step;

  // Bounds and layer clamps.
  assign w_lim = (WCW'(cfg_i.frame_width) > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH)
                                                             : WCW'(cfg_i.frame_width);
  assign h_lim = (HCW'(cfg_i.frame_height) > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT)
                                                               : HCW'(cfg_i.frame_height);
  assign in_bounds = (WCW'(x_q) < w_lim) && (HCW'(y_q) < h_lim);

  always_comb begin
    if (cfg_i.num_layers == 5'd0) begin
      n_lim = NCW'(1);
    end else if (NCW'(cfg_i.num_layers) > NCW'(LAYERS)) begin
      n_lim = NCW'(LAYERS);
    end else begin
      n_lim = NCW'(cfg_i.num_layers);
    end
    n_max = n_lim - NCW'(1);
    tgt   = (NCW'(target_layer_i) > n_max) ? n_max : NCW'(target_layer_i);
  end

  // Shared step unit: one layer down means one pixel plane down in the store.
  assign addr_step  = addr_q - AW'(NPIX);
  assign layer_step = layer_q - LW'(1);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    active_d = active_q;
    vis_d    = vis_q;
    p_d      = p_q;
    base_d   = base_q;
    addr_d   = addr_q;
    layer_d  = layer_q;
    shown_d  = shown_q;

    pix_we    = 1'b0;
    pix_waddr = addr_q;
    pix_wdata = col_q;
    pix_re    = 1'b0;
    pix_raddr = addr_step;
    top_we    = 1'b0;
    top_waddr = p_q;
    top_wdata = layer_q;
    top_re    = 1'b0;
    top_raddr = p_q;

    res_o       = '0;
    res_o.kind  = KIND_PIXEL;

    unique case (state_q)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_q;
        pix_wdata = '0;
        top_we    = ({1'b0, clr_q} < (AW + 1)'(NPIX));
        top_waddr = clr_q[PW-1:0];
        top_wdata = '0;
        if (clr_q == AW'(TOTAL - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_WRITE:  state_d = ST_CHECK;
            OP_SELECT: active_d = LW'(tgt);
            OP_SEND:   state_d = ST_SEND;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CHECK: begin
        p_d    = PW'(y_q * MAX_WIDTH + x_q);
        base_d = AW'(active_q * NPIX);
        state_d = in_bounds ? ST_ADDR : ST_IDLE;
      end
      ST_ADDR: begin
        addr_d  = base_q + AW'(p_q);
        layer_d = active_q;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        pix_we  = 1'b1;
        top_re  = 1'b1;
        state_d = ST_TOP;
      end
      ST_TOP: begin
        if (layer_q < top_rdata) begin
          state_d = ST_IDLE;
        end else begin
          vis_d   = 1'b1;
          shown_d = col_q;
          if ((col_q != 24'd0) || (layer_q == '0)) begin
            state_d = ST_FIN;
          end else begin
            pix_re  = 1'b1;
            addr_d  = addr_step;
            layer_d = layer_step;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Read data belongs to layer_q; stop on color or at the bottom layer.
        if ((pix_rdata != 24'd0) || (layer_q == '0)) begin
          shown_d = pix_rdata;
          state_d = ST_FIN;
        end else begin
          pix_re  = 1'b1;
          addr_d  = addr_step;
          layer_d = layer_step;
        end
      end
      ST_FIN: begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_PIXEL;
        res_o.x     = x_q;
        res_o.y     = y_q;
        res_o.red   = shown_q[23:16];
        res_o.green = shown_q[15:8];
        res_o.blue  = shown_q[7:0];
        if (res_ready_i) begin
          top_we  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!vis_q) begin
          state_d = ST_IDLE;
        end else begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_FRAME;
          if (res_ready_i) begin
            vis_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      active_q <= '0;
      vis_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      active_q <= active_d;
      vis_q    <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_x_i;
      y_q   <= in_y_i;
      col_q <= {in_red_i, in_green_i, in_blue_i};
    end
    p_q     <= p_d;
    base_q  <= base_d;
    addr_q  <= addr_d;
    layer_q <= layer_d;
    shown_q <= shown_d;
  end

  lpc_ram #(
    .WIDTH (24),
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  lpc_ram #(
    .WIDTH (LW),
    .DEPTH (NPIX),
    .AW    (PW)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (top_wdata),
    .re_i    (top_re),
    .raddr_i (top_raddr),
    .rdata_o (top_rdata)
  );

endmodule

// ----- hdl/layered_pixel_compositor_unit.sv -----
// Top level of the layered pixel compositor: configuration, sequencer and output register.
//
//   Channel   Handshake                  Direction  Carries
//   in        in_valid_i / in_ready_o    in         opcode, position, layer, color
//   out       out_valid_o / out_ready_i  out        kind, position, visible color
//   cfg       cfg_valid_i / cfg_ready_o  in         register index and data
//
// A select item or an unused opcode leaves the sequencer in ST_IDLE; a send item passes
// through ST_SEND, a dropped write through ST_CHECK, a hidden write through ST_CHECK,
// ST_ADDR, ST_WRITE and ST_TOP, and a visible write also through ST_FIN. A black write
// adds one ST_WALK step for each layer walked below the active layer, since the pixel
// store has a single read port. After reset the stores are cleared one entry a cycle,
// with in_ready_o low; configuration writes are always taken. A result waits in the
// output register; the sequencer stalls only when it has a new result and that register
// is still full.
module layered_pixel_compositor_unit #(
  parameter int MAX_WIDTH  = lpc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lpc_pkg::DEF_MAX_HEIGHT,
  parameter int LAYERS     = lpc_pkg::DEF_LAYERS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [5:0]                     in_x_i,
  input  logic [5:0]                     in_y_i,
  input  logic [3:0]                     target_layer_i,
  input  logic [7:0]                     in_red_i,
  input  logic [7:0]                     in_green_i,
  input  logic [7:0]                     in_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_kind_o,
  output logic [5:0]                     out_x_o,
  output logic [5:0]                     out_y_o,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpc_pkg::*;

  cfg_t       cfg_q;
  res_t       res;
  logic       res_ready;
  logic       out_valid_q, out_valid_d;
  logic       load;
  logic       out_kind_q;
  logic [5:0] out_x_q, out_y_q;
  logic [7:0] out_red_q, out_green_q, out_blue_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.num_layers   <= RST_NUM_LAYERS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[6:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[6:0];
        CFG_NUM_LAYERS:   cfg_q.num_layers   <= cfg_data_i[4:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  lpc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LAYERS     (LAYERS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .target_layer_i (target_layer_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .res_o          (res),
    .res_ready_i    (res_ready)
  );

  // The output register takes a new result when it is empty or drains this cycle.
  assign res_ready = !out_valid_q || out_ready_i;
  assign load      = res.valid && res_ready;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= res.kind;
      out_x_q     <= res.x;
      out_y_q     <= res.y;
      out_red_q   <= res.red;
      out_green_q <= res.green;
      out_blue_q  <= res.blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;

  // A frame strobe carries no position and no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_FRAME)) |->
      ((out_x_o == 6'd0) && (out_y_o == 6'd0) && (out_red_o == 8'd0) &&
       (out_green_o == 8'd0) && (out_blue_o == 8'd0)))
    else $error("frame strobe with nonzero fields");

  // While the sequencer is ready for input it has no result pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res.valid)
    else $error("result pending while accepting input");

  // Select, send and unused items never produce a display pixel right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i != OP_WRITE)) |=>
      !(res.valid && (res.kind == KIND_PIXEL)))
    else $error("pixel result from a non-write item");

endmodule

// ----- verif/tb_layered_pixel_compositor_unit.sv -----
// Self-checking testbench for the layered pixel compositor, with its own predictor.
`timescale 1ns / 100ps

module tb_layered_pixel_compositor_unit;
  import lpc_pkg::*;

  localparam int NPIX          = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 32;
  localparam int RUN_LIMIT     = 800_000;

  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] x;
    logic [5:0] y;
    logic [3:0] layer;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } screen_update_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            opcode_i;
  logic [5:0]            in_x_i;
  logic [5:0]            in_y_i;
  logic [3:0]            target_layer_i;
  logic [7:0]            in_red_i;
  logic [7:0]            in_green_i;
  logic [7:0]            in_blue_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  out_kind_o;
  logic [5:0]            out_x_o;
  logic [5:0]            out_y_o;
  logic [7:0]            out_red_o;
  logic [7:0]            out_green_o;
  logic [7:0]            out_blue_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor state: a copy of every layer store, the top index and the registers.
  logic [23:0] layer_store [DEF_LAYERS * NPIX];
  logic [3:0]  top_index   [NPIX];
  logic [3:0]  cur_layer;
  bit          drawn_flag;
  logic [6:0]  cfg_w;
  logic [6:0]  cfg_h;
  logic [4:0]  cfg_layers;

  screen_update_t update_q [$];
  screen_update_t want;

  int  cycle_count;
  int  error_count;
  int  items_sent;
  int  n_visible;
  int  n_see_through;
  int  n_hidden;
  int  n_dropped;
  int  n_strobes;
  int  hold_left;
  bit  sender_gaps_on;
  bit  sink_stalls_on;

  layered_pixel_compositor_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .in_x_i         (in_x_i),
    .in_y_i         (in_y_i),
    .target_layer_i (target_layer_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
        $display("%0t ns: timeout after %0d cycles, %0d results still due",
                 $time, cycle_count, update_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: a long hold-off request takes priority over the random stalls.
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_val, int unsigned got);
    if (exp_val != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (update_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got kind %0d x %0d y %0d rgb %h%h%h",
                 $time, out_kind_o, out_x_o, out_y_o, out_red_o, out_green_o, out_blue_o);
        error_count++;
      end else begin
        want = update_q.pop_front();
        check_field("out_kind", want.kind, out_kind_o);
        check_field("out_x", want.x, out_x_o);
        check_field("out_y", want.y, out_y_o);
        check_field("out_red", want.red, out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue", want.blue, out_blue_o);
      end
    end
  end

  task automatic clear_model();
    for (int i = 0; i < DEF_LAYERS * NPIX; i++) layer_store[i] = '0;
    for (int i = 0; i < NPIX; i++) top_index[i] = '0;
    cur_layer  = '0;
    drawn_flag = 1'b0;
    cfg_w      = RST_FRAME_WIDTH;
    cfg_h      = RST_FRAME_HEIGHT;
    cfg_layers = RST_NUM_LAYERS;
  endtask

  // Applies one accepted request to the predictor and queues the update it shows.
  task automatic composite_cmd(input pixel_cmd_t c);
    int w;
    int h;
    int n;
    int pix;
    int lyr;
    logic [23:0] col;
    logic [23:0] shown;
    screen_update_t upd;
    upd = '0;
    case (c.op)
      OP_WRITE: begin
        w = (cfg_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_w;
        h = (cfg_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_h;
        if (int'(c.x) >= w || int'(c.y) >= h) begin
          n_dropped++;
        end else begin
          pix = int'(c.y) * DEF_MAX_WIDTH + int'(c.x);
          lyr = cur_layer;
          col = {c.red, c.green, c.blue};
          layer_store[lyr * NPIX + pix] = col;
          if (lyr < top_index[pix]) begin
            n_hidden++;
          end else begin
            drawn_flag = 1'b1;
            n_visible++;
            // Black is see-through: fall to the nearest colored layer below.
            if (col == '0) begin
              n_see_through++;
              while (lyr > 0 && layer_store[lyr * NPIX + pix] == '0) lyr--;
            end
            shown = layer_store[lyr * NPIX + pix];
            top_index[pix] = lyr[3:0];
            upd.kind = KIND_PIXEL;
            upd.x = c.x;
            upd.y = c.y;
            {upd.red, upd.green, upd.blue} = shown;
            update_q = {update_q, upd};
          end
        end
      end
      OP_SELECT: begin
        n = cfg_layers;
        if (n < 1) n = 1;
        if (n > DEF_LAYERS) n = DEF_LAYERS;
        cur_layer = (int'(c.layer) > n - 1) ? 4'(n - 1) : c.layer;
      end
      OP_SEND: begin
        if (drawn_flag) begin
          upd.kind = KIND_FRAME;
          update_q = {update_q, upd};
          n_strobes++;
        end
        drawn_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Valid stays high from one request to the next when there is no gap.
  task automatic send_cmd(input pixel_cmd_t c);
    int gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= c.op;
    in_x_i         <= c.x;
    in_y_i         <= c.y;
    target_layer_i <= c.layer;
    in_red_i       <= c.red;
    in_green_i     <= c.green;
    in_blue_i      <= c.blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    composite_cmd(c);
    items_sent++;
  endtask

  function automatic pixel_cmd_t make_cmd(logic [1:0] op, logic [5:0] x, logic [5:0] y,
                                          logic [3:0] lyr, logic [23:0] rgb);
    pixel_cmd_t c;
    c.op = op;
    c.x = x;
    c.y = y;
    c.layer = lyr;
    {c.red, c.green, c.blue} = rgb;
    return c;
  endfunction

  // Mostly writes into a small corner so that layers pile up on the same pixels.
  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t c;
    int pick;
    c.x     = 6'($urandom_range(0, 63));
    c.y     = 6'($urandom_range(0, 63));
    c.layer = 4'($urandom_range(0, 15));
    c.red   = 8'($urandom_range(0, 255));
    c.green = 8'($urandom_range(0, 255));
    c.blue  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) != 0) begin
      c.x = 6'($urandom_range(0, 3));
      c.y = 6'($urandom_range(0, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.op = OP_WRITE;
    end else if (pick < 66) begin
      c.op = OP_WRITE;
      {c.red, c.green, c.blue} = '0;
    end else if (pick < 84) begin
      c.op = OP_SELECT;
    end else if (pick < 95) begin
      c.op = OP_SEND;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // Waits until every due result is out and any result-free request has finished.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (update_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [6:0] w, input logic [6:0] h, input logic [6:0] n,
                              input bit poke_unused);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idx  [4];
    int last;
    vals = '{w, h, n, 7'h55};
    idx  = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_NUM_LAYERS, CFG_UNUSED};
    last = poke_unused ? 3 : 2;
    settle();
    for (int i = 0; i <= last; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        CFG_FRAME_WIDTH:  cfg_w = vals[i];
        CFG_FRAME_HEIGHT: cfg_h = vals[i];
        CFG_NUM_LAYERS:   cfg_layers = vals[i][4:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Layer stacking, see-through writes and frame strobes at the reset settings.
  task automatic test_directed_layers();
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h123456));
    send_cmd(make_cmd(OP_WRITE, 6'd63, 6'd63, 4'd15, 24'hFFFFFF));
    send_cmd(make_cmd(OP_SEND, 6'd63, 6'd0, 4'd0, 24'h0));
    send_cmd(make_cmd(OP_SEND, 6'd0, 6'd63, 4'd0, 24'h0));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd15, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'hA5A5A5));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd3, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h5A5A5A));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd15, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd15, 24'h000000));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd0, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h000000));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd3, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h000000));
    send_cmd(make_cmd(OP_UNUSED, 6'd63, 6'd63, 4'd15, 24'hFFFFFF));
    send_cmd(make_cmd(OP_SEND, 6'd0, 6'd0, 4'd0, 24'h0));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd7, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd10, 6'd20, 4'd0, 24'h000000));
    send_cmd(make_cmd(OP_WRITE, 6'd5, 6'd5, 4'd0, 24'h0000FF));
  endtask

  // Register extremes: zero size, single pixel, oversized values and layer clamping.
  task automatic test_register_extremes();
    program_regs(7'd0, 7'd0, 7'd0, 1'b0);
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h808080));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd15, 24'h0));
    send_cmd(make_cmd(OP_SEND, 6'd0, 6'd0, 4'd0, 24'h0));
    program_regs(7'd1, 7'd1, 7'h7F, 1'b0);
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd0, 4'd0, 24'h010203));
    send_cmd(make_cmd(OP_WRITE, 6'd1, 6'd0, 4'd0, 24'h010203));
    send_cmd(make_cmd(OP_WRITE, 6'd0, 6'd1, 4'd0, 24'h010203));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd15, 24'h0));
    // The active layer keeps its value when the layer count drops below it.
    program_regs(7'd127, 7'd127, 7'd2, 1'b1);
    send_cmd(make_cmd(OP_WRITE, 6'd63, 6'd63, 4'd0, 24'h00FF00));
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd15, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd63, 6'd63, 4'd0, 24'hFF0000));
    program_regs(7'd64, 7'd64, 7'd1, 1'b0);
    send_cmd(make_cmd(OP_SELECT, 6'd0, 6'd0, 4'd9, 24'h0));
    send_cmd(make_cmd(OP_WRITE, 6'd63, 6'd0, 4'd0, 24'h000000));
  endtask

  task automatic test_random_traffic();
    logic [6:0] w_set [6];
    logic [6:0] h_set [6];
    logic [6:0] n_set [6];
    w_set = '{7'd64, 7'd8, 7'd127, 7'd4, 7'd64, 7'($urandom_range(1, 127))};
    h_set = '{7'd64, 7'd8, 7'd100, 7'd64, 7'd3, 7'($urandom_range(1, 127))};
    n_set = '{7'd16, 7'd4, 7'd31, 7'd1, 7'd0, 7'($urandom_range(0, 31))};
    for (int ph = 0; ph < 6; ph++) begin
      program_regs(w_set[ph], h_set[ph], n_set[ph], 1'b0);
      for (int i = 0; i < 140; i++) begin
        if (i % 40 == 0) begin
          sender_gaps_on = ($urandom_range(0, 3) != 0);
          sink_stalls_on = ($urandom_range(0, 3) != 0);
        end
        send_cmd(random_cmd());
      end
    end
  endtask

  // The result side holds off while requests keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    program_regs(7'd16, 7'd16, 7'd16, 1'b0);
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    hold_left = 400;
    for (int i = 0; i < 60; i++) send_cmd(random_cmd());
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_WRITE;
    in_x_i         = '0;
    in_y_i         = '0;
    target_layer_i = '0;
    in_red_i       = '0;
    in_green_i     = '0;
    in_blue_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_FRAME_WIDTH;
    cfg_data_i     = '0;
    error_count    = 0;
    items_sent     = 0;
    n_visible      = 0;
    n_see_through  = 0;
    n_hidden       = 0;
    n_dropped      = 0;
    n_strobes      = 0;
    hold_left      = 0;
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    clear_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_layers();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    settle();

    $display("Sent %0d requests: %0d visible writes (%0d see-through), %0d hidden, %0d dropped.",
             items_sent, n_visible, n_see_through, n_hidden, n_dropped);
    $display("Frame strobes: %0d, mismatches: %0d, cycles: %0d.",
             n_strobes, error_count, cycle_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lpc_pkg.sv
hdl/lpc_ram.sv
hdl/lpc_seq.sv
hdl/layered_pixel_compositor_unit.sv
verif/tb_layered_pixel_compositor_unit.sv
